// ----- rtl/core/pwbm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwbm_pkg
// Shared widths, codes and controller/datapath link types for the peak
// window bitrate monitor.
// ----------------------------------------------------------------------------
package pwbm_pkg;

  // Field widths
  localparam int BYTES_W = 24;
  localparam int TICKS_W = 16;
  localparam int TS_W    = 20;
  localparam int RATE_W  = 32;

  // Time scale after reset (ticks per second)
  localparam logic [TS_W-1:0] TIME_SCALE_RESET = 20'd44100;

  // Input word kinds carried on tuser
  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_FINALIZE = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;    // take input word, store frame on add
    logic init;      // set up walk pointer, clear sums
    logic walk;      // issue ring read, accumulate previous read
    logic mul_load;  // clear product, load time scale
    logic mul_step;  // one shift-add step
    logic div_load;  // load dividend and divisor
    logic div_step;  // one restoring division step
    logic publish;   // write result word, update peak
  } pwbm_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic walk_done;
    logic compute_ok;
    logic mul_last;
    logic div_last;
    logic out_free;
  } pwbm_sts_t;

endpackage

// ----- rtl/core/peak_window_bitrate_monitor.sv -----
// Sequence: each input word goes through setup, the walk over the newest frames
// (at most DEPTH frames summed), multiply, divide load, divide and publish;
// with no rate the walk goes straight to publish.
// Flow: one word at a time; the next is taken in the cycle after the publish,
// later while the output register waits.
// Reset (rst, synchronous): ring empty, peak zero, time scale 44100.
// ----------------------------------------------------------------------------
// peak_window_bitrate_monitor
// Peak sliding-window bitrate of a coded frame stream: sums the newest
// frames until their duration reaches the time scale and forms rounded
// bits per second, tracking the highest window seen.
// ----------------------------------------------------------------------------
module peak_window_bitrate_monitor
  import pwbm_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [BYTES_W+TICKS_W-1:0] s_tdata,   // frame_bytes[23:0], frame_ticks[39:24]
  input  logic                       s_tuser,   // command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [2*RATE_W-1:0]        m_tdata,   // window_rate[31:0], peak_rate[63:32]
  output logic                       m_tuser,   // computed
  input  logic                       cfg_we,
  input  logic [TS_W-1:0]            cfg_wdata  // time_scale
);

  pwbm_cmd_t cmd;
  pwbm_sts_t sts;

  pwbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwbm_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/core/pwbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pwbm_ctrl
// Sequencer for one word: store, walk back over the ring, multiply,
// divide, publish.
// ----------------------------------------------------------------------------
module pwbm_ctrl
  import pwbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  pwbm_sts_t sts,
  output pwbm_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INIT = 7'b0000010,
    S_WALK = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIVL = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No word is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.accept = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          if (sts.compute_ok) begin
            cmd.mul_load = 1'b1;
            state_next   = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_next = S_DIVL;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is never written over one still waiting downstream
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> sts.out_free)
    else $error("publish while output register busy");

  // The last division step always leads to the result state
  a_div_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_last) |=> (state == S_DONE))
    else $error("division did not end in result state");
`endif

endmodule

// ----- rtl/core/pwbm_dpath.sv -----
// ----------------------------------------------------------------------------
// pwbm_dpath
// Frame ring, window sums, shift-add multiplier, restoring divider,
// peak register and output register.
// ----------------------------------------------------------------------------
module pwbm_dpath
  import pwbm_pkg::*;
#(
  parameter int DEPTH = 64
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  pwbm_cmd_t                  cmd,
  output pwbm_sts_t                  sts,
  input  logic [BYTES_W+TICKS_W-1:0] s_tdata,
  input  logic                       s_tuser,
  input  logic                       cfg_we,
  input  logic [TS_W-1:0]            cfg_wdata,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [2*RATE_W-1:0]        m_tdata,
  output logic                       m_tuser
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = BYTES_W + $clog2(DEPTH);   // byte sum
  localparam int TW   = TS_W + 1;                  // tick sum stays below 2*2^TS_W
  localparam int PW   = SW + TS_W;                 // S*T
  localparam int NW   = PW + 5;                    // 16*S*T + D
  localparam int DVW  = TW + 1;                    // 2*D
  localparam int SCW  = $clog2(NW);
  localparam int WW   = BYTES_W + TICKS_W;

  // Configuration and ring control
  logic [TS_W-1:0] time_scale;
  logic [AW-1:0]   write_slot;
  logic [CW-1:0]   stored_count;
  logic            finalize;

  // Ring memory and walk
  logic [WW-1:0]   ring [DEPTH];
  logic [WW-1:0]   rd_word;
  logic            rd_valid;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   walk_cnt;
  logic [SW-1:0]   sum_b;
  logic [TW-1:0]   sum_t;
  logic            walk_done;
  logic            compute_ok;
  logic            comp_flag;

  // Multiply / divide
  logic [PW-1:0]   acc;
  logic [TS_W-1:0] t_sh;
  logic [SCW-1:0]  step_cnt;
  logic [NW-1:0]   quo;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dv;
  logic [DVW:0]    trial;
  logic            trial_ge;

  // Result
  logic [RATE_W-1:0] rate_val;
  logic [RATE_W-1:0] peak_value;
  logic [RATE_W-1:0] peak_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale <= TIME_SCALE_RESET;
    end else if (cfg_we) begin
      time_scale <= cfg_wdata;
    end
  end

  // Ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      stored_count <= '0;
    end else if (cmd.accept && s_tuser == CMD_ADD) begin
      write_slot <= (write_slot == AW'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
      if (stored_count != CW'(DEPTH)) begin
        stored_count <= stored_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      finalize <= (s_tuser == CMD_FINALIZE);
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && s_tuser == CMD_ADD) begin
      ring[write_slot] <= s_tdata;
    end
    if (cmd.walk) begin
      rd_word <= ring[rd_ptr];
    end
  end

  // Walk stops after all stored frames or once the tick sum reaches the scale
  assign walk_done  = (walk_cnt == stored_count) || (sum_t >= {1'b0, time_scale});
  assign compute_ok = (sum_t != '0) && (finalize || (sum_t >= {1'b0, time_scale}));

  // Walk back from the newest frame; each read is registered and summed by the next walk step
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.init) begin
      rd_valid <= 1'b0;
    end else if (cmd.walk) begin
      rd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      rd_ptr   <= (write_slot == '0) ? AW'(DEPTH - 1) : write_slot - 1'b1;
      walk_cnt <= '0;
      sum_b    <= '0;
      sum_t    <= '0;
    end else if (cmd.walk) begin
      rd_ptr <= (rd_ptr == '0) ? AW'(DEPTH - 1) : rd_ptr - 1'b1;
      if (rd_valid && !walk_done) begin
        walk_cnt <= walk_cnt + 1'b1;
        sum_b    <= sum_b + SW'(rd_word[BYTES_W-1:0]);
        sum_t    <= sum_t + TW'(rd_word[WW-1:BYTES_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && walk_done) begin
      comp_flag <= compute_ok;
    end
  end

  // Shift-add multiply S*T (MSB of T first), then restoring divide
  assign trial    = {rem, quo[NW-1]};
  assign trial_ge = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      acc      <= '0;
      t_sh     <= time_scale;
      step_cnt <= '0;
    end else if (cmd.mul_step) begin
      acc      <= {acc[PW-2:0], 1'b0} + (t_sh[TS_W-1] ? PW'(sum_b) : '0);
      t_sh     <= {t_sh[TS_W-2:0], 1'b0};
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.div_load) begin
      quo      <= {1'b0, acc, 4'b0000} + NW'(sum_t);
      dv       <= {sum_t, 1'b0};
      rem      <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= trial_ge ? DVW'(trial - {1'b0, dv}) : trial[DVW-1:0];
      quo      <= {quo[NW-2:0], trial_ge};
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Saturated rate and peak
  always_comb begin
    if (!comp_flag) begin
      rate_val = '0;
    end else if (|quo[NW-1:RATE_W]) begin
      rate_val = '1;
    end else begin
      rate_val = quo[RATE_W-1:0];
    end
    peak_next = (rate_val > peak_value) ? rate_val : peak_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value <= '0;
    end else if (cmd.publish) begin
      peak_value <= peak_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      m_tdata <= {peak_next, rate_val};
      m_tuser <= comp_flag;
    end
  end

  // Status
  always_comb begin
    sts            = '0;
    sts.walk_done  = walk_done;
    sts.compute_ok = compute_ok;
    sts.mul_last   = (step_cnt == SCW'(TS_W - 1));
    sts.div_last   = (step_cnt == SCW'(NW - 1));
    sts.out_free   = !m_tvalid || m_tready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(DEPTH))
    else $error("fill count beyond ring depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= AW'(DEPTH - 1))
    else $error("write slot beyond ring depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < dv))
    else $error("division remainder not below divisor");
`endif

endmodule
